// ===== rtl/stl_pkg.sv =====
// Shared types and constants for the sorted time list.
package stl_pkg;

  localparam int TIME_W    = 27;
  localparam int POS_W     = 6;
  localparam int OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              cmp_en;
    logic              ins_en;
    logic              rem_en;
    logic [TIME_W-1:0] time_v;
    logic [POS_W-1:0]  pos;
  } cell_ctrl_t;

endpackage

// ===== rtl/stl_ifs.sv =====
// Valid/ready channel interfaces for command and result beats.
interface stl_in_if import stl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [TIME_W-1:0] time_value;
  logic [POS_W-1:0]  position;

  modport source (output valid, action, time_value, position, input ready);
  modport sink   (input valid, action, time_value, position, output ready);
endinterface

interface stl_out_if import stl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] entry_count;
  logic [TIME_W-1:0]    read_value;

  modport source (output valid, status, entry_count, read_value, input ready);
  modport sink   (input valid, status, entry_count, read_value, output ready);
endinterface

// ===== rtl/stl_cell.sv =====
// One list slot: holds a time, compares it, shifts left or right with its neighbors.
module stl_cell import stl_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  input  logic [TIME_W-1:0] left_val,
  input  logic              left_gt,
  input  logic              left_eq,
  input  logic [TIME_W-1:0] right_val,
  output logic [TIME_W-1:0] val,
  output logic              gt,
  output logic              eq,
  output logic              match,
  output logic [TIME_W-1:0] rd_part
);

  logic [TIME_W-1:0] val_r;
  logic              gt_r;
  logic              ge_r;
  logic              match_r;
  logic              occ;
  logic              at_end;
  logic              gt_c;
  logic              ge_c;

  assign occ    = 32'(IDX) < 32'(count);
  assign at_end = 32'(IDX) == 32'(count);
  assign eq     = occ && (val_r == ctrl.time_v);
  assign gt_c   = occ && (ctrl.time_v < val_r);
  assign ge_c   = occ && !(val_r < ctrl.time_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r    <= 1'b0;
      ge_r    <= 1'b0;
      match_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      gt_r    <= gt_c;
      ge_r    <= ge_c;
      match_r <= eq && !left_eq;   // first of a run of equal times
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (left_gt) begin
        val_r <= left_val;
      end else if (gt_r || at_end) begin
        val_r <= ctrl.time_v;
      end
    end else if (ctrl.rem_en && ge_r) begin
      val_r <= right_val;
    end
  end

  assign val     = val_r;
  assign gt      = gt_r;
  assign match   = match_r;
  assign rd_part = (occ && (32'(ctrl.pos) == 32'(IDX))) ? val_r : '0;

endmodule

// ===== rtl/stl_cell_row.sv =====
// Chain of list cells with match and read-out combining.
module stl_cell_row import stl_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  output logic              found,
  output logic [TIME_W-1:0] rd_val
);

  logic [TIME_W-1:0] vals    [CAPACITY];
  logic [TIME_W-1:0] rd_part [CAPACITY];
  logic [CAPACITY-1:0] gts;
  logic [CAPACITY-1:0] eqs;
  logic [CAPACITY-1:0] first_hits;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [TIME_W-1:0] lv;
    logic [TIME_W-1:0] rv;
    logic              lg;
    logic              le;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
      assign le = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
      assign le = eqs[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = vals[i+1];
    end

    stl_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .count     (count),
      .left_val  (lv),
      .left_gt   (lg),
      .left_eq   (le),
      .right_val (rv),
      .val       (vals[i]),
      .gt        (gts[i]),
      .eq        (eqs[i]),
      .match     (first_hits[i]),
      .rd_part   (rd_part[i])
    );
  end

  assign found = |first_hits;

  // at most one cell is addressed, so an OR combines the read-out
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | rd_part[i];
    end
  end

  // equal times sit together, so only one cell can open the run
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(first_hits))
    else $error("more than one first-match cell");

endmodule

// ===== rtl/sorted_time_list_top.sv =====
// Top level of the sorted time list: command sequencer, cell row and result register.
//
//  channel | dir | beat contents                         | accepted when
//  in_ch   | in  | action, time_value, position          | valid && ready
//  out_ch  | out | status, entry_count, read_value       | valid && ready
//
// An item goes through accept, compare in every cell and update/shift, in that order.
// The compare and the shift each span the whole cell row; the sequencer holds
// one item at a time, so a new item is taken only after the last one's update.
// Reset (rst_n low, synchronous) empties the list; stored times are not cleared.
// A result waits in the output register; the next beat is taken meanwhile and
// its update stalls only while that register is still full.
// CAPACITY sets the cell count (2..1024); entry_count shows the low 7 bits.
module sorted_time_list_top import stl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_ch,
  stl_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [1:0]        act_r;
  logic [TIME_W-1:0] time_r;
  logic [POS_W-1:0]  pos_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [TIME_W-1:0] rd_r;
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [TIME_W-1:0] read_r;
  logic [TIME_W-1:0] read_nxt;
  logic [31:0]       count_wide;

  cell_ctrl_t        ctrl;
  logic              found;
  logic [TIME_W-1:0] rd_val;
  logic              accept;
  logic              upd_go;
  logic              full;
  logic              in_range;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign upd_go      = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign full        = (count_r == CW'(CAPACITY));
  assign in_range    = 32'(pos_r) < 32'(count_r);

  assign ctrl.cmp_en = (state_r == S_CMP);
  assign ctrl.ins_en = upd_go && (act_r == ACT_INSERT) && !full;
  assign ctrl.rem_en = upd_go && (act_r == ACT_REMOVE) && found;
  assign ctrl.time_v = time_r;
  assign ctrl.pos    = pos_r;

  stl_cell_row #(.CAPACITY(CAPACITY), .CW(CW)) u_row (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .count  (count_r),
    .found  (found),
    .rd_val (rd_val)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result and new count for the item in the update cycle
  always_comb begin
    status_nxt = ST_OK;
    read_nxt   = '0;
    count_nxt  = count_r;
    unique case (act_r)
      ACT_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      ACT_READ: begin
        if (in_range) begin
          read_nxt = rd_r;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_ch.action;
      time_r <= in_ch.time_value;
      pos_r  <= in_ch.position;
    end
    if (state_r == S_CMP) begin
      rd_r <= rd_val;
    end
    if (upd_go) begin
      status_r <= status_nxt;
      read_r   <= read_nxt;
    end
  end

  assign count_wide         = 32'(count_r);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = count_wide[OUT_CNT_W-1:0];
  assign out_ch.read_value  = read_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count past capacity");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && act_r == ACT_READ) |=> $stable(count_r))
    else $error("read changed the entry count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && act_r == ACT_INSERT && full) |=> (count_r == CW'(CAPACITY)))
    else $error("dropped insert changed the count");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> (out_valid_r && state_r == S_IDLE))
    else $error("update did not post a result");

endmodule

// ===== tb/sorted_time_list_top_test.sv =====
// Testbench for sorted_time_list_top: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module sorted_time_list_top_test import stl_pkg::*; ();

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    action_t             action;
    logic [TIME_W-1:0]   time_value;
    logic [POS_W-1:0]    position;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [TIME_W-1:0]    read_value;
  } res_t;

  // One directed row: the command and, where it is obvious, its result.
  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t want;
  } row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;
  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_e;

  // Directed walk: empty-list corners, both time extremes, duplicates,
  // a remove miss, reads in and out of range and the unused action code.
  localparam int DIRECTED_LEN = 22;
  localparam row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{'{ACT_READ,   27'd0,        6'd0},  1'b1, '{ST_RANGE,     7'd0, 27'd0}},
    '{'{ACT_REMOVE, 27'd0,        6'd0},  1'b1, '{ST_NOT_FOUND, 7'd0, 27'd0}},
    '{'{ACT_NOP,    TIME_MAX,     6'd63}, 1'b1, '{ST_OK,        7'd0, 27'd0}},
    '{'{ACT_INSERT, TIME_MAX,     6'd0},  1'b1, '{ST_OK,        7'd1, 27'd0}},
    '{'{ACT_INSERT, 27'd0,        6'd63}, 1'b1, '{ST_OK,        7'd2, 27'd0}},
    '{'{ACT_READ,   27'd0,        6'd0},  1'b1, '{ST_OK,        7'd2, 27'd0}},
    '{'{ACT_READ,   TIME_MAX,     6'd1},  1'b1, '{ST_OK,        7'd2, TIME_MAX}},
    '{'{ACT_READ,   27'd0,        6'd2},  1'b1, '{ST_RANGE,     7'd2, 27'd0}},
    '{'{ACT_READ,   27'd0,        6'd63}, 1'b1, '{ST_RANGE,     7'd2, 27'd0}},
    '{'{ACT_INSERT, 27'h2AAAAAA,  6'd21}, 1'b0, '0},
    '{'{ACT_INSERT, 27'h5555555,  6'd42}, 1'b0, '0},
    '{'{ACT_INSERT, 27'd100,      6'd0},  1'b0, '0},
    '{'{ACT_INSERT, 27'd100,      6'd0},  1'b0, '0},
    '{'{ACT_READ,   27'd0,        6'd2},  1'b0, '0},
    '{'{ACT_REMOVE, 27'd100,      6'd0},  1'b0, '0},
    '{'{ACT_REMOVE, 27'd12345,    6'd0},  1'b1, '{ST_NOT_FOUND, 7'd5, 27'd0}},
    '{'{ACT_REMOVE, TIME_MAX,     6'd0},  1'b0, '0},
    '{'{ACT_READ,   27'd0,        6'd3},  1'b0, '0},
    '{'{ACT_REMOVE, 27'd0,        6'd0},  1'b0, '0},
    '{'{ACT_NOP,    27'd0,        6'd0},  1'b0, '0},
    '{'{ACT_READ,   27'd0,        6'd0},  1'b0, '0},
    '{'{ACT_INSERT, TIME_MAX - 1, 6'd0},  1'b0, '0}
  };

  logic clk;
  logic rst_n;

  stl_in_if  in_ch ();
  stl_out_if out_ch ();

  sorted_time_list_top #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the list as it must be after every accepted beat.
  logic [TIME_W-1:0] held_times [$];
  res_t              pending_results [$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int beats_sent   = 0;
  int work_items   = 0;
  int burst_left   = 0;
  int peak_fill    = 0;
  int full_hits    = 0;
  int status_seen [4];

  sink_mode_e sink_mode;
  int         sink_left;
  int         sink_tick;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit: far above the slowest legal run, sender gaps and receiver stalls included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[sorted_time_list_top] ERROR");
      $finish;
    end
  end

  // Apply one command to the predicted list and return the result it gives.
  // Inserts go after every equal value; removes take the lowest match.
  function automatic res_t apply_to_list(cmd_t c);
    res_t r;
    int   slot;
    int   hit;
    r.status     = ST_OK;
    r.read_value = '0;
    case (c.action)
      ACT_INSERT: begin
        if (held_times.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = held_times.size();
          while (slot > 0 && c.time_value < held_times[slot-1]) slot--;
          held_times.insert(slot, c.time_value);
        end
      end
      ACT_REMOVE: begin
        hit = -1;
        foreach (held_times[i]) begin
          if (hit < 0 && held_times[i] == c.time_value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          held_times.delete(hit);
        end
      end
      ACT_READ: begin
        if (int'(c.position) < held_times.size()) begin
          r.read_value = held_times[c.position];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;  // unused code: list untouched
    endcase
    r.entry_count = OUT_CNT_W'(held_times.size());
    return r;
  endfunction

  // Time values: full range, a dense pool for duplicates, a pool up to 1000, stored
  // values (so removes hit), and the extremes.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 4))
      0: return TIME_W'($urandom);
      1: return TIME_W'($urandom_range(0, 15));
      2: begin
        if (held_times.size() > 0) return held_times[$urandom_range(0, held_times.size() - 1)];
        return TIME_W'($urandom_range(0, 15));
      end
      3: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return TIME_MAX;
          2: return TIME_W'(1);
          default: return TIME_MAX - 1;
        endcase
      end
      default: return TIME_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic cmd_t next_cmd(phase_e ph);
    cmd_t c;
    int   roll;
    roll         = $urandom_range(0, 99);
    c.time_value = pick_time();
    c.position   = POS_W'($urandom);
    c.action     = ACT_READ;
    case (ph)
      PH_FILL: c.action = (roll < 85) ? ACT_INSERT : ACT_READ;
      PH_DRAIN: begin
        if (roll < 90) c.action = ACT_REMOVE;
        // mostly remove something that is stored
        if (roll < 80 && held_times.size() > 0) begin
          c.time_value = held_times[$urandom_range(0, held_times.size() - 1)];
        end
      end
      default: c.action = (roll < 4) ? ACT_NOP : action_t'(2'(roll % 3));
    endcase
    // reads land inside the list most of the time
    if (c.action == ACT_READ && held_times.size() > 0 && $urandom_range(0, 2) != 0) begin
      c.position = POS_W'($urandom_range(0, held_times.size() - 1));
    end
    return c;
  endfunction

  // Present one beat in bursts with random gaps; called and left just after
  // a falling edge. The expectation is queued at the falling edge after
  // acceptance, so it is never raced by the result monitor.
  task automatic send_beat(input cmd_t c, input logic typed, input res_t want);
    int   gap;
    res_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.action     = c.action;
    in_ch.time_value = c.time_value;
    in_ch.position   = c.position;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    predicted = apply_to_list(c);
    pending_results.push_back(typed ? want : predicted);
    if (predicted.status == ST_FULL) full_hits++;
    if (held_times.size() > peak_fill) peak_fill = held_times.size();
    beats_sent++;
    burst_left--;
  endtask

  // Hold the sender until every queued result has come back.
  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: stall pattern switches between open, light, heavy and periodic.
  initial begin
    out_ch.ready = 1'b0;
    sink_mode    = SINK_OPEN;
    sink_left    = 0;
    sink_tick    = 0;
    forever begin
      @(negedge clk);
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_left = $urandom_range(40, 250);
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
        SINK_OPEN:  out_ch.ready = 1'b1;
        SINK_LIGHT: out_ch.ready = ($urandom_range(0, 3) != 0);
        SINK_HEAVY: out_ch.ready = ($urandom_range(0, 2) == 0);
        default:    out_ch.ready = ((sink_tick % 7) < 4);
      endcase
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d count %0d value 0x%0h",
               out_ch.status, out_ch.entry_count, out_ch.read_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_ch.entry_count);
          fail_count++;
        end
        if (out_ch.read_value !== want.read_value) begin
          $error("read_value: expected 0x%0h, got 0x%0h", want.read_value, out_ch.read_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    phase_e ph;
    int     phase_len;
    logic   paused_once;
    cmd_t   c;

    paused_once      = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_NOP;
    in_ch.time_value = '0;
    in_ch.position   = '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_beat(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // Random phases: fill runs push the list to full and past it, drain
    // runs empty it through matching removes, mixed runs cover the rest.
    while (work_items < RANDOM_ITEMS) begin
      ph        = phase_e'($urandom_range(0, 2));
      phase_len = (ph == PH_MIXED) ? $urandom_range(20, 80) : $urandom_range(40, 110);
      repeat (phase_len) begin
        c = next_cmd(ph);
        send_beat(c, 1'b0, '0);
        if (c.action != ACT_NOP) work_items++;
      end
      if (!paused_once || $urandom_range(0, 3) == 0) begin
        wait_results_drained();
        paused_once = 1'b1;
      end
    end

    wait_results_drained();
    repeat (10) @(posedge clk);

    $display("%0d beats in %0d cycles, list peaked at %0d entries, %0d dropped inserts",
             beats_sent, cycle_count, peak_fill, full_hits);
    $display("results by status: ok %0d, not found %0d, full %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_RANGE]);
    if (fail_count == 0) begin
      $display("[sorted_time_list_top] OK");
    end else begin
      $display("[sorted_time_list_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stl_pkg.sv
rtl/stl_ifs.sv
rtl/stl_cell.sv
rtl/stl_cell_row.sv
rtl/sorted_time_list_top.sv
tb/sorted_time_list_top_test.sv
